// File: sv/rcec_pkg.sv
package rcec_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam int MODE_W = 2;
    localparam int DEV_W  = 4;
    localparam int ITEM_W = 16;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_GET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PUT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNREF = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

    localparam logic [CNT_W-1:0] REF_MAX = '1;

    typedef struct packed {
        logic capture;
        logic scan;
        logic pick;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: sv/rcec_datapath.sv
module rcec_datapath
    import rcec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_dp_status,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [DEV_W-1:0]    i_device,
    input  logic [ITEM_W-1:0]   i_item_number,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [SLOT_W-1:0]   o_result_slot,
    output logic                o_hit,
    output logic [CNT_W-1:0]    o_count_after,
    output logic [STAT_W-1:0]   o_status
);

    logic [MODE_W-1:0] r_mode;
    logic [DEV_W-1:0]  r_dev;
    logic [ITEM_W-1:0] r_item;
    logic [SLOT_W-1:0] r_slot;

    logic [DEV_W-1:0]  r_key_dev  [ENTRIES];
    logic [ITEM_W-1:0] r_key_item [ENTRIES];
    logic [ENTRIES-1:0] r_live;
    logic [CNT_W-1:0]  r_refs_mem [ENTRIES];

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_free;

    logic [IDX_W-1:0]  pick_idx;
    logic [IDX_W-1:0]  r_idx;
    logic              r_hit;
    logic              r_any_free;
    logic [CNT_W-1:0]  r_rd_data;

    logic              cur_live;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;
    logic              slot_in_range;
    logic              mem_we;
    logic [CNT_W-1:0]  mem_wdata;
    logic              claim;
    logic              live_clr;
    logic [SLOT_W-1:0] n_out_slot;
    logic              n_out_hit;
    logic [CNT_W-1:0]  n_out_cnt;
    logic [STAT_W-1:0] n_out_status;

    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_hit;
    logic [CNT_W-1:0]  r_out_cnt;
    logic [STAT_W-1:0] r_out_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_dev  <= i_device;
            r_item <= i_item_number;
            r_slot <= i_slot;
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = r_live[i] && (r_key_dev[i] == r_dev) && (r_key_item[i] == r_item);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_match <= match_vec;
            r_free  <= ~r_live;
        end
    end

    always_comb begin
        if (r_mode == MODE_GET) begin
            pick_idx = (|r_match) ? first_set(r_match) : first_set(r_free);
        end else begin
            pick_idx = IDX_W'(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_idx      <= pick_idx;
            r_hit      <= |r_match;
            r_any_free <= |r_free;
            r_rd_data  <= r_refs_mem[pick_idx];
        end
        if (i_cmd.exec && mem_we) begin
            r_refs_mem[r_idx] <= mem_wdata;
        end
    end

    assign slot_in_range = 32'(r_slot) < ENTRIES;
    assign cur_live      = r_live[r_idx];
    assign cur_cnt       = cur_live ? r_rd_data : '0;
    assign cnt_inc       = cur_cnt + CNT_W'(1);
    assign cnt_dec       = cur_cnt - CNT_W'(1);

    always_comb begin
        n_out_slot   = SLOT_W'(r_idx);
        n_out_hit    = 1'b0;
        n_out_cnt    = '0;
        n_out_status = ST_OK;
        mem_we       = 1'b0;
        mem_wdata    = cnt_inc;
        claim        = 1'b0;
        live_clr     = 1'b0;
        unique case (r_mode) inside
            MODE_GET: begin
                if (r_hit) begin
                    n_out_hit = 1'b1;
                    if (cur_cnt == REF_MAX) begin
                        n_out_cnt    = REF_MAX;
                        n_out_status = ST_SAT;
                    end else begin
                        mem_we    = 1'b1;
                        n_out_cnt = cnt_inc;
                    end
                end else if (!r_any_free) begin
                    n_out_slot   = '0;
                    n_out_status = ST_FULL;
                end else begin
                    claim     = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = CNT_W'(1);
                    n_out_cnt = CNT_W'(1);
                end
            end
            MODE_DUP, MODE_PUT: begin
                n_out_slot = r_slot;
                if (!slot_in_range || !cur_live) begin
                    n_out_status = ST_UNREF;
                end else if (r_mode == MODE_DUP) begin
                    if (cur_cnt == REF_MAX) begin
                        n_out_cnt    = REF_MAX;
                        n_out_status = ST_SAT;
                    end else begin
                        mem_we    = 1'b1;
                        n_out_cnt = cnt_inc;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = cnt_dec;
                    n_out_cnt = cnt_dec;
                    live_clr  = (cnt_dec == '0);
                end
            end
            default: begin
                n_out_slot   = r_slot;
                n_out_status = ST_UNREF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (i_cmd.exec) begin
            if (claim) begin
                r_live[r_idx] <= 1'b1;
            end
            if (live_clr) begin
                r_live[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && claim) begin
            r_key_dev[r_idx]  <= r_dev;
            r_key_item[r_idx] <= r_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_slot   <= n_out_slot;
            r_out_hit    <= n_out_hit;
            r_out_cnt    <= n_out_cnt;
            r_out_status <= n_out_status;
        end
    end

    assign o_dp_status.out_free = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_result_slot = r_out_slot;
    assign o_hit         = r_out_hit;
    assign o_count_after = r_out_cnt;
    assign o_status      = r_out_status;

endmodule

// File: sv/rcec_ctrl.sv
module rcec_ctrl
    import rcec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_dp_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (i_dp_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// File: sv/refcounted_entry_cache.sv
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_mode, i_device, i_item_number, i_slot
// response  out        o_valid / i_stall  o_result_slot, o_hit, o_count_after, o_status
//
// Each request steps through accept, parallel key compare, first-match or first-free
// pick (given slot for dup/put) with count memory read, then update and result load.
// The count memory has one port, so its read and write take separate cycles.
// A result still waiting at the output holds the update cycle, and the request
// input stays stalled until that result has been taken.
// Reset is synchronous and clears the live flags, the state and the output valid.
module refcounted_entry_cache
    import rcec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [DEV_W-1:0]    i_device,
    input  logic [ITEM_W-1:0]   i_item_number,
    input  logic [SLOT_W-1:0]   i_slot,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SLOT_W-1:0]   o_result_slot,
    output logic                o_hit,
    output logic [CNT_W-1:0]    o_count_after,
    output logic [STAT_W-1:0]   o_status
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    rcec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_dp_status (dp_status),
        .o_cmd       (dp_cmd)
    );

    rcec_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_dp_status   (dp_status),
        .i_mode        (i_mode),
        .i_device      (i_device),
        .i_item_number (i_item_number),
        .i_slot        (i_slot),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result_slot (o_result_slot),
        .o_hit         (o_hit),
        .o_count_after (o_count_after),
        .o_status      (o_status)
    );

endmodule

// File: sv/rcec_checker.sv
module rcec_checker
    import rcec_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [SLOT_W-1:0]   o_result_slot,
    input logic                o_hit,
    input logic [CNT_W-1:0]    o_count_after,
    input logic [STAT_W-1:0]   o_status
);

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("response dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request transfer not followed by busy");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> (o_status == ST_OK || o_status == ST_SAT))
        else $error("hit with full or unreferenced status");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |->
            o_result_slot == '0 && o_count_after == '0 && !o_hit)
        else $error("table full result carries data");

    a_unref_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_UNREF |-> o_count_after == '0 && !o_hit)
        else $error("unreferenced result carries a count");

endmodule

bind refcounted_entry_cache rcec_checker u_rcec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_slot (o_result_slot),
    .o_hit         (o_hit),
    .o_count_after (o_count_after),
    .o_status      (o_status)
);

// File: dv/tb_refcounted_entry_cache.sv
module tb_refcounted_entry_cache;
    import rcec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int KEY_POOL = 40;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] status;
    } t_lookup_result;

    class refcount_tracker;
        logic [CNT_W-1:0]  refs[ENTRIES];
        logic [DEV_W-1:0]  key_dev[ENTRIES];
        logic [ITEM_W-1:0] key_item[ENTRIES];
        t_lookup_result    due_results[$];
        int                errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                refs[i] = '0;
            end
            errors = 0;
        endfunction

        function int free_slots();
            int n;
            n = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (refs[i] == '0) begin
                    n++;
                end
            end
            return n;
        endfunction

        function logic [SLOT_W-1:0] pick_live_slot();
            logic [SLOT_W-1:0] s;
            s = SLOT_W'($urandom);
            for (int tries = 0; tries < 64; tries++) begin
                s = SLOT_W'($urandom_range(ENTRIES - 1));
                if (refs[s] != '0) begin
                    return s;
                end
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (refs[i] != '0) begin
                    return SLOT_W'(i);
                end
            end
            return s;
        endfunction

        function void apply_request(input logic [MODE_W-1:0] mode,
                                    input logic [DEV_W-1:0] dev,
                                    input logic [ITEM_W-1:0] item,
                                    input logic [SLOT_W-1:0] slot);
            t_lookup_result r;
            int free_idx;
            r = '0;
            free_idx = -1;
            if (mode == MODE_GET) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (refs[i] != '0 && key_dev[i] == dev && key_item[i] == item) begin
                        r.slot = SLOT_W'(i);
                        r.hit = 1'b1;
                        if (refs[i] == REF_MAX) begin
                            r.count = REF_MAX;
                            r.status = ST_SAT;
                        end else begin
                            refs[i] = refs[i] + 1'b1;
                            r.count = refs[i];
                            r.status = ST_OK;
                        end
                        due_results.push_back(r);
                        return;
                    end
                    if (free_idx < 0 && refs[i] == '0) begin
                        free_idx = i;
                    end
                end
                if (free_idx < 0) begin
                    r.status = ST_FULL;
                end else begin
                    key_dev[free_idx] = dev;
                    key_item[free_idx] = item;
                    refs[free_idx] = 8'd1;
                    r.slot = SLOT_W'(free_idx);
                    r.count = 8'd1;
                    r.status = ST_OK;
                end
            end else if ((mode != MODE_DUP && mode != MODE_PUT) || int'(slot) >= ENTRIES
                         || refs[slot] == '0) begin
                r.slot = slot;
                r.status = ST_UNREF;
            end else if (mode == MODE_DUP && refs[slot] == REF_MAX) begin
                r.slot = slot;
                r.count = REF_MAX;
                r.status = ST_SAT;
            end else begin
                if (mode == MODE_DUP) begin
                    refs[slot] = refs[slot] + 1'b1;
                end else begin
                    refs[slot] = refs[slot] - 1'b1;
                end
                r.slot = slot;
                r.count = refs[slot];
                r.status = ST_OK;
            end
            due_results.push_back(r);
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_response(input t_lookup_result got);
            t_lookup_result want;
            if (due_results.size() == 0) begin
                report($sformatf("response with nothing outstanding, slot %0d", got.slot));
                return;
            end
            want = due_results.pop_front();
            if (got.slot != want.slot) begin
                report($sformatf("result_slot %0d, expected %0d", got.slot, want.slot));
            end
            if (got.hit != want.hit) begin
                report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
            end
            if (got.count != want.count) begin
                report($sformatf("count_after %0d, expected %0d", got.count, want.count));
            end
            if (got.status != want.status) begin
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic req_valid;
    logic [MODE_W-1:0] req_mode;
    logic [DEV_W-1:0] req_device;
    logic [ITEM_W-1:0] req_item;
    logic [SLOT_W-1:0] req_slot;
    logic rsp_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic [SLOT_W-1:0] o_result_slot;
    logic o_hit;
    logic [CNT_W-1:0] o_count_after;
    logic [STAT_W-1:0] o_status;

    int send_idle_pct;
    int recv_idle_pct;
    logic [DEV_W-1:0] pool_dev[KEY_POOL];
    logic [ITEM_W-1:0] pool_item[KEY_POOL];
    refcount_tracker tracker = new();

    refcounted_entry_cache i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (req_valid),
        .o_stall       (o_stall),
        .i_mode        (req_mode),
        .i_device      (req_device),
        .i_item_number (req_item),
        .i_slot        (req_slot),
        .o_valid       (o_valid),
        .i_stall       (rsp_stall),
        .o_result_slot (o_result_slot),
        .o_hit         (o_hit),
        .o_count_after (o_count_after),
        .o_status      (o_status)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !rsp_stall) begin
            tracker.check_response({o_result_slot, o_hit, o_count_after, o_status});
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [DEV_W-1:0] dev,
                                input logic [ITEM_W-1:0] item, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge i_clk);
        end
        req_valid = 1'b1;
        req_mode = mode;
        req_device = dev;
        req_item = item;
        req_slot = slot;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        tracker.apply_request(mode, dev, item, slot);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        req_valid = 1'b0;
        while (tracker.due_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic send_random_request();
        int pick;
        int k;
        pick = $urandom_range(99);
        k = $urandom_range(KEY_POOL - 1);
        if (pick < 42) begin
            if ($urandom_range(9) < 7) begin
                send_request(MODE_GET, pool_dev[k], pool_item[k], SLOT_W'($urandom));
            end else begin
                send_request(MODE_GET, DEV_W'($urandom), ITEM_W'($urandom), SLOT_W'($urandom));
            end
        end else if (pick < 94) begin
            send_request((pick < 62) ? MODE_DUP : MODE_PUT, DEV_W'($urandom),
                         ITEM_W'($urandom),
                         ($urandom_range(9) < 8) ? tracker.pick_live_slot() : SLOT_W'($urandom));
        end else begin
            send_request(MODE_NONE, DEV_W'($urandom), ITEM_W'($urandom), SLOT_W'($urandom));
        end
    endtask

    initial begin
        logic [SLOT_W-1:0] s;
        req_valid = 1'b0;
        req_mode = MODE_GET;
        req_device = '0;
        req_item = '0;
        req_slot = '0;
        send_idle_pct = 22;
        recv_idle_pct = 56;
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_dev[k] = DEV_W'($urandom);
            pool_item[k] = ITEM_W'($urandom);
        end
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(MODE_GET, 4'd0, 16'h0000, 6'd0);
        send_request(MODE_GET, 4'd15, 16'hFFFF, 6'd63);
        send_request(MODE_GET, 4'd0, 16'h0000, 6'd0);
        send_request(MODE_GET, 4'd15, 16'h0000, 6'd0);
        send_request(MODE_GET, 4'd0, 16'hFFFF, 6'd0);
        send_request(MODE_DUP, 4'd0, 16'h0000, 6'd1);
        send_request(MODE_PUT, 4'd0, 16'h0000, 6'd1);
        send_request(MODE_PUT, 4'd0, 16'h0000, 6'd1);
        send_request(MODE_PUT, 4'd0, 16'h0000, 6'd1);
        send_request(MODE_DUP, 4'd0, 16'h0000, 6'd1);
        send_request(MODE_GET, 4'd9, 16'h1234, 6'd0);
        send_request(MODE_NONE, 4'd0, 16'h0000, 6'd63);
        send_request(MODE_NONE, 4'd15, 16'hFFFF, 6'd0);
        send_request(MODE_DUP, 4'd0, 16'h0000, 6'd63);
        send_request(MODE_PUT, 4'd0, 16'h0000, 6'd63);
        send_request(MODE_PUT, 4'd0, 16'h0000, 6'd0);
        send_request(MODE_PUT, 4'd0, 16'h0000, 6'd0);
        // Both keys were held by slots since freed, and a freed slot keeps its old key; neither get may hit.
        send_request(MODE_GET, 4'd15, 16'hFFFF, 6'd0);
        send_request(MODE_GET, 4'd0, 16'h0000, 6'd0);
        drain_results();

        while (tracker.free_slots() > 0) begin
            send_request(MODE_GET, DEV_W'($urandom), ITEM_W'($urandom), SLOT_W'($urandom));
        end
        repeat (3) begin
            send_request(MODE_GET, DEV_W'($urandom), ITEM_W'($urandom), SLOT_W'($urandom));
        end
        s = tracker.pick_live_slot();
        send_request(MODE_GET, tracker.key_dev[s], tracker.key_item[s], 6'd0);
        for (int i = 0; i < ENTRIES; i += 2) begin
            while (tracker.refs[i] != '0) begin
                send_request(MODE_PUT, 4'd0, 16'h0000, SLOT_W'(i));
            end
        end
        repeat (200) send_random_request();
        drain_results();

        send_idle_pct = 56;
        recv_idle_pct = 22;
        s = tracker.pick_live_slot();
        if (tracker.refs[s] == '0) begin
            send_request(MODE_GET, 4'd7, 16'h5A5A, 6'd0);
            s = tracker.pick_live_slot();
        end
        while (tracker.refs[s] != REF_MAX) begin
            send_request(MODE_DUP, DEV_W'($urandom), ITEM_W'($urandom), s);
        end
        send_request(MODE_DUP, 4'd0, 16'h0000, s);
        send_request(MODE_GET, tracker.key_dev[s], tracker.key_item[s], 6'd0);
        send_request(MODE_PUT, 4'd0, 16'h0000, s);
        send_request(MODE_GET, tracker.key_dev[s], tracker.key_item[s], 6'd0);
        send_request(MODE_GET, tracker.key_dev[s], tracker.key_item[s], 6'd0);
        repeat (250) send_random_request();
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (250) send_random_request();
        drain_results();
        repeat (10) @(negedge i_clk);

        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

// File: refcounted_entry_cache.f
sv/rcec_pkg.sv
sv/rcec_datapath.sv
sv/rcec_ctrl.sv
sv/refcounted_entry_cache.sv
sv/rcec_checker.sv
dv/tb_refcounted_entry_cache.sv
